FILE: rtl/gbsp_pkg.sv
package gbsp_pkg;

    // Parser phases, one-hot.
    typedef enum logic [12:0] {
        PH_SIG       = 13'b0_0000_0000_0001,
        PH_SCREEN    = 13'b0_0000_0000_0010,
        PH_GCT       = 13'b0_0000_0000_0100,
        PH_MARK      = 13'b0_0000_0000_1000,
        PH_EXT_LABEL = 13'b0_0000_0001_0000,
        PH_EXT_SIZE  = 13'b0_0000_0010_0000,
        PH_EXT_DATA  = 13'b0_0000_0100_0000,
        PH_IMG_DESC  = 13'b0_0000_1000_0000,
        PH_LCT       = 13'b0_0001_0000_0000,
        PH_LZW       = 13'b0_0010_0000_0000,
        PH_IMG_SIZE  = 13'b0_0100_0000_0000,
        PH_IMG_DATA  = 13'b0_1000_0000_0000,
        PH_DONE      = 13'b1_0000_0000_0000
    } t_phase;

    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_SIG_OK     = 4'd1,
        EV_BAD_SIG    = 4'd2,
        EV_SCREEN     = 4'd3,
        EV_GCT_ENTRY  = 4'd4,
        EV_EXT_START  = 4'd5,
        EV_EXT_END    = 4'd6,
        EV_IMAGE_DESC = 4'd7,
        EV_LCT_ENTRY  = 4'd8,
        EV_LZW_SIZE   = 4'd9,
        EV_IMAGE_END  = 4'd10,
        EV_TRAILER    = 4'd11,
        EV_BAD_MARKER = 4'd12
    } t_event;

    localparam logic [7:0] BLK_EXTENSION = 8'h21;
    localparam logic [7:0] BLK_IMAGE     = 8'h2C;
    localparam logic [7:0] BLK_TRAILER   = 8'h3B;
    localparam logic [7:0] SIG_VER_87    = 8'h37;
    localparam logic [7:0] TABLE_SIZE_MASK = 8'b0000_0111;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  hdr_pos;
        logic        sig_bad;
        logic [1:0]  tbl_mod3;
        logic [7:0]  tbl_index;
        logic [7:0]  subblock_left;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [15:0] word_d;
        logic [7:0]  flag_byte;
        logic [15:0] color_shift;
        logic [8:0]  entries_total;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        phase:         PH_SIG,
        hdr_pos:       4'd0,
        sig_bad:       1'b0,
        tbl_mod3:      2'd0,
        tbl_index:     8'd0,
        subblock_left: 8'd0,
        word_a:        16'd0,
        word_b:        16'd0,
        word_c:        16'd0,
        word_d:        16'd0,
        flag_byte:     8'd0,
        color_shift:   16'd0,
        entries_total: 9'd0
    };

    typedef struct packed {
        t_event      event_res;
        logic [15:0] field_a;
        logic [15:0] field_b;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  packed_flags;
        logic [8:0]  table_entries;
        logic [23:0] rgb_color;
        logic        inc_image;
        logic        inc_ext;
    } t_step_out;

    function automatic logic [7:0] sig_byte(input logic [2:0] pos);
        logic [7:0] val;
        case (pos)
            3'd0:    val = 8'h47;
            3'd1:    val = 8'h49;
            3'd2:    val = 8'h46;
            3'd3:    val = 8'h38;
            3'd4:    val = 8'h39;
            3'd5:    val = 8'h61;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // Color table size from a packed flag byte, zero when the table flag is clear.
    function automatic logic [8:0] color_table_len(input logic [7:0] flags);
        logic [2:0] sz;
        sz = 3'(flags & TABLE_SIZE_MASK);
        return flags[7] ? (9'd2 << sz) : 9'd0;
    endfunction

endpackage

FILE: rtl/gbsp_step.sv
module gbsp_step (
    input  gbsp_pkg::t_parse_state i_state,
    input  logic [7:0]             i_data_byte,
    output gbsp_pkg::t_parse_state o_state,
    output gbsp_pkg::t_step_out    o_res
);
    import gbsp_pkg::*;

    t_parse_state n;
    t_step_out    res;
    logic         sig_miss;
    logic         tbl_last;

    always_comb begin
        n        = i_state;
        res      = '0;
        sig_miss = 1'b0;
        tbl_last = 1'b0;
        res.event_res = EV_NONE;

        unique case (i_state.phase) inside
            PH_SIG: begin
                sig_miss = i_state.sig_bad |
                           ~((i_data_byte == sig_byte(i_state.hdr_pos[2:0])) ||
                             (i_state.hdr_pos == 4'd4 && i_data_byte == SIG_VER_87));
                if (i_state.hdr_pos >= 4'd5) begin
                    res.event_res = sig_miss ? EV_BAD_SIG : EV_SIG_OK;
                    n.phase   = sig_miss ? PH_DONE : PH_SCREEN;
                    n.hdr_pos = 4'd0;
                    n.sig_bad = 1'b0;
                end else begin
                    n.sig_bad = sig_miss;
                    n.hdr_pos = i_state.hdr_pos + 4'd1;
                end
            end
            PH_SCREEN: begin
                case (i_state.hdr_pos)
                    4'd0:    n.word_a = {8'h00, i_data_byte};
                    4'd1:    n.word_a = {i_data_byte, i_state.word_a[7:0]};
                    4'd2:    n.word_b = {8'h00, i_data_byte};
                    4'd3:    n.word_b = {i_data_byte, i_state.word_b[7:0]};
                    4'd4:    n.flag_byte = i_data_byte;
                    default: ;
                endcase
                if (i_state.hdr_pos >= 4'd6) begin
                    n.entries_total   = color_table_len(i_state.flag_byte);
                    res.event_res     = EV_SCREEN;
                    res.field_a       = i_state.word_a;
                    res.field_b       = i_state.word_b;
                    res.packed_flags  = i_state.flag_byte;
                    res.table_entries = n.entries_total;
                    n.phase     = (n.entries_total != 9'd0) ? PH_GCT : PH_MARK;
                    n.hdr_pos   = 4'd0;
                    n.tbl_mod3  = 2'd0;
                    n.tbl_index = 8'd0;
                end else begin
                    n.hdr_pos = i_state.hdr_pos + 4'd1;
                end
            end
            PH_GCT, PH_LCT: begin
                // Red and green are shifted in; blue completes the entry.
                if (i_state.tbl_mod3 != 2'd2) begin
                    n.color_shift = {i_state.color_shift[7:0], i_data_byte};
                    n.tbl_mod3    = i_state.tbl_mod3 + 2'd1;
                end else begin
                    tbl_last = ({1'b0, i_state.tbl_index} + 9'd1) >= i_state.entries_total;
                    res.event_res = (i_state.phase == PH_GCT) ? EV_GCT_ENTRY : EV_LCT_ENTRY;
                    res.field_a   = {8'h00, i_state.tbl_index};
                    res.rgb_color = {i_state.color_shift, i_data_byte};
                    n.tbl_mod3    = 2'd0;
                    if (tbl_last) begin
                        n.phase     = (i_state.phase == PH_GCT) ? PH_MARK : PH_LZW;
                        n.tbl_index = 8'd0;
                    end else begin
                        n.tbl_index = i_state.tbl_index + 8'd1;
                    end
                end
            end
            PH_MARK: begin
                if (i_data_byte == BLK_EXTENSION) begin
                    n.phase = PH_EXT_LABEL;
                end else if (i_data_byte == BLK_IMAGE) begin
                    n.phase   = PH_IMG_DESC;
                    n.hdr_pos = 4'd0;
                end else if (i_data_byte == BLK_TRAILER) begin
                    res.event_res = EV_TRAILER;
                    n.phase       = PH_DONE;
                end else begin
                    res.event_res = EV_BAD_MARKER;
                    res.field_a   = {8'h00, i_data_byte};
                    n.phase       = PH_DONE;
                end
            end
            PH_EXT_LABEL: begin
                res.event_res = EV_EXT_START;
                res.field_a   = {8'h00, i_data_byte};
                res.inc_ext   = 1'b1;
                n.phase       = PH_EXT_SIZE;
            end
            PH_EXT_SIZE, PH_IMG_SIZE: begin
                if (i_data_byte == 8'd0) begin
                    if (i_state.phase == PH_EXT_SIZE) begin
                        res.event_res = EV_EXT_END;
                    end else begin
                        res.event_res = EV_IMAGE_END;
                        res.inc_image = 1'b1;
                    end
                    n.phase = PH_MARK;
                end else begin
                    n.subblock_left = i_data_byte;
                    n.phase = (i_state.phase == PH_EXT_SIZE) ? PH_EXT_DATA : PH_IMG_DATA;
                end
            end
            PH_EXT_DATA, PH_IMG_DATA: begin
                n.subblock_left = i_state.subblock_left - 8'd1;
                if (n.subblock_left == 8'd0) begin
                    n.phase = (i_state.phase == PH_EXT_DATA) ? PH_EXT_SIZE : PH_IMG_SIZE;
                end
            end
            PH_IMG_DESC: begin
                case (i_state.hdr_pos)
                    4'd0:    n.word_a = {8'h00, i_data_byte};
                    4'd1:    n.word_a = {i_data_byte, i_state.word_a[7:0]};
                    4'd2:    n.word_b = {8'h00, i_data_byte};
                    4'd3:    n.word_b = {i_data_byte, i_state.word_b[7:0]};
                    4'd4:    n.word_c = {8'h00, i_data_byte};
                    4'd5:    n.word_c = {i_data_byte, i_state.word_c[7:0]};
                    4'd6:    n.word_d = {8'h00, i_data_byte};
                    4'd7:    n.word_d = {i_data_byte, i_state.word_d[7:0]};
                    default: n.flag_byte = i_data_byte;
                endcase
                if (i_state.hdr_pos >= 4'd8) begin
                    n.entries_total   = color_table_len(i_data_byte);
                    res.event_res     = EV_IMAGE_DESC;
                    res.field_a       = i_state.word_a;
                    res.field_b       = i_state.word_b;
                    res.image_width   = i_state.word_c;
                    res.image_height  = i_state.word_d;
                    res.packed_flags  = i_data_byte;
                    res.table_entries = n.entries_total;
                    n.phase       = (n.entries_total != 9'd0) ? PH_LCT : PH_LZW;
                    n.hdr_pos     = 4'd0;
                    n.tbl_mod3    = 2'd0;
                    n.tbl_index   = 8'd0;
                    n.color_shift = 16'd0;
                end else begin
                    n.hdr_pos = i_state.hdr_pos + 4'd1;
                end
            end
            PH_LZW: begin
                res.event_res = EV_LZW_SIZE;
                res.field_a   = {8'h00, i_data_byte};
                n.phase       = PH_IMG_SIZE;
            end
            default: begin
                n.phase = PH_DONE;
            end
        endcase
    end

    assign o_state = n;
    assign o_res   = res;

endmodule

FILE: rtl/gif_block_structure_parser_unit.sv
// Channel   Dir  tdata                        tuser
// s_*       in   data_byte [7:0]              restart [0]
// m_*       out  result fields, 137 bits      event_res [3:0]
//
// One byte in, one event out. A byte is taken into an input register, decoded
// combinationally by the phase logic and written to the result register, so a
// new transfer can be accepted every cycle unless the master side stalls.
// Reset (synchronous, active low) returns the parser to the signature phase and
// clears both counters. A stall on the master side holds the result register;
// the input register still fills, then the slave side backs up.
module gif_block_structure_parser_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  logic         i_s_tuser,   // [0] restart
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [15:0] field_a, [31:16] field_b, [47:32] image_width, [63:48] image_height,
    // [71:64] packed_flags, [80:72] table_entries, [104:81] rgb_color,
    // [120:105] image_total, [136:121] extension_count, [143:137] zero
    output logic [143:0] o_m_tdata,
    output logic [3:0]   o_m_tuser    // [3:0] event_res
);
    import gbsp_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_restart;
    t_parse_state          r_state;
    logic [COUNT_BITS-1:0] r_images_seen;
    logic [COUNT_BITS-1:0] r_exts_seen;
    logic                  r_out_valid;
    t_step_out             r_out;
    logic [15:0]           r_out_images;
    logic [15:0]           r_out_exts;

    logic                  out_ready;
    logic                  consume;
    t_parse_state          cur_state;
    t_parse_state          n_state;
    t_step_out             step_res;
    logic [COUNT_BITS-1:0] cur_images;
    logic [COUNT_BITS-1:0] cur_exts;
    logic [COUNT_BITS-1:0] n_images_seen;
    logic [COUNT_BITS-1:0] n_exts_seen;

    assign out_ready  = !r_out_valid || i_m_tready;
    assign consume    = r_in_valid && out_ready;
    assign o_s_tready = !r_in_valid || out_ready;

    // A restart item is decoded from the reset state.
    assign cur_state  = r_in_restart ? PARSE_RESET : r_state;
    assign cur_images = r_in_restart ? '0 : r_images_seen;
    assign cur_exts   = r_in_restart ? '0 : r_exts_seen;

    gbsp_step u_step (
        .i_state     (cur_state),
        .i_data_byte (r_in_byte),
        .o_state     (n_state),
        .o_res       (step_res)
    );

    assign n_images_seen = (step_res.inc_image && cur_images != '1) ?
                           cur_images + COUNT_BITS'(1) : cur_images;
    assign n_exts_seen   = (step_res.inc_ext && cur_exts != '1) ?
                           cur_exts + COUNT_BITS'(1) : cur_exts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_state       <= PARSE_RESET;
            r_images_seen <= '0;
            r_exts_seen   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (consume) begin
                r_state       <= n_state;
                r_images_seen <= n_images_seen;
                r_exts_seen   <= n_exts_seen;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte    <= i_s_tdata;
            r_in_restart <= i_s_tuser;
        end
        if (consume) begin
            r_out        <= step_res;
            r_out_images <= 16'(n_images_seen);
            r_out_exts   <= 16'(n_exts_seen);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.event_res;
    assign o_m_tdata  = {7'd0, r_out_exts, r_out_images, r_out.rgb_color,
                         r_out.table_entries, r_out.packed_flags, r_out.image_height,
                         r_out.image_width, r_out.field_b, r_out.field_a};

    // The state register always reflects the item held in the result register.
    a_trailer_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == EV_TRAILER) |-> (r_state.phase == PH_DONE))
        else $error("trailer event without done phase");

    a_lzw_then_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res == EV_LZW_SIZE) |-> (r_state.phase == PH_IMG_SIZE))
        else $error("lzw size event not followed by sub-block size phase");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && !r_in_restart && r_state.phase == PH_DONE)
        |=> (r_state.phase == PH_DONE))
        else $error("parser left done phase without restart");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && !r_in_restart) |=> (r_images_seen >= $past(r_images_seen)))
        else $error("image count decreased without restart");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import gbsp_pkg::*;

    localparam int COUNT_W = 16;
    localparam logic [47:0] GIF_MAGIC = "GIF89a";

    typedef struct packed {
        t_event      ev;
        logic [15:0] field_a;
        logic [15:0] field_b;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  packed_flags;
        logic [8:0]  table_entries;
        logic [23:0] rgb_color;
        logic [15:0] image_total;
        logic [15:0] extension_count;
    } t_gif_event;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_s_tvalid;
    logic           o_s_tready;
    logic [7:0]     i_s_tdata;   // [7:0] data_byte
    logic           i_s_tuser;   // [0] restart
    logic           o_m_tvalid;
    logic           i_m_tready;
    // [15:0] field_a, [31:16] field_b, [47:32] image_width, [63:48] image_height,
    // [71:64] packed_flags, [80:72] table_entries, [104:81] rgb_color,
    // [120:105] image_total, [136:121] extension_count, [143:137] zero
    logic [143:0]   o_m_tdata;
    logic [3:0]     o_m_tuser;   // [3:0] event_res

    t_gif_event     pending_events[$];
    logic [7:0]     file_bytes[$];
    int unsigned    mismatches = 0;
    int unsigned    bytes_sent = 0;
    logic           idle_on = 1'b1;

    // Shadow of the parser state.
    t_phase         gif_phase;
    int unsigned    hdr_pos;
    logic           sig_mismatch;
    logic [7:0]     sub_left;
    logic [15:0]    acc_x, acc_y, acc_w, acc_h;
    logic [7:0]     desc_flags;
    logic [15:0]    color_hi;
    logic [8:0]     table_len;
    int unsigned    images_done;
    int unsigned    extensions_done;

    gif_block_structure_parser_unit #(
        .COUNT_BITS(COUNT_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [8:0] color_count(input logic [7:0] flags);
        return flags[7] ? (9'd2 << flags[2:0]) : 9'd0;
    endfunction

    function automatic int unsigned bump_count(input int unsigned c);
        longint unsigned lim;
        lim = (64'd1 << COUNT_W) - 64'd1;
        return (64'(c) < lim) ? c + 32'd1 : 32'(lim);
    endfunction

    function automatic void clear_parser();
        gif_phase = PH_SIG;
        hdr_pos = 0;
        sig_mismatch = 1'b0;
        sub_left = '0;
        acc_x = '0;
        acc_y = '0;
        acc_w = '0;
        acc_h = '0;
        desc_flags = '0;
        color_hi = '0;
        table_len = '0;
        images_done = 0;
        extensions_done = 0;
    endfunction

    // Advances the shadow state by one byte and returns the event it causes.
    function automatic t_gif_event parse_byte(input logic [7:0] b, input logic restart);
        t_gif_event  r;
        int unsigned idx;
        r = '0;
        if (restart) clear_parser();
        case (gif_phase)
            PH_SIG: begin
                if (!(b == GIF_MAGIC[8 * (5 - hdr_pos % 6) +: 8] ||
                      (hdr_pos == 4 && b == SIG_VER_87)))
                    sig_mismatch = 1'b1;
                if (hdr_pos >= 5) begin
                    r.ev = sig_mismatch ? EV_BAD_SIG : EV_SIG_OK;
                    gif_phase = sig_mismatch ? PH_DONE : PH_SCREEN;
                    hdr_pos = 0;
                    sig_mismatch = 1'b0;
                end else begin
                    hdr_pos++;
                end
            end
            PH_SCREEN: begin
                case (hdr_pos)
                    0: acc_x = {8'h00, b};
                    1: acc_x[15:8] = b;
                    2: acc_y = {8'h00, b};
                    3: acc_y[15:8] = b;
                    4: desc_flags = b;
                    default: ;
                endcase
                if (hdr_pos >= 6) begin
                    table_len = color_count(desc_flags);
                    r.ev = EV_SCREEN;
                    r.field_a = acc_x;
                    r.field_b = acc_y;
                    r.packed_flags = desc_flags;
                    r.table_entries = table_len;
                    gif_phase = (table_len != 0) ? PH_GCT : PH_MARK;
                    hdr_pos = 0;
                end else begin
                    hdr_pos++;
                end
            end
            PH_GCT, PH_LCT: begin
                if (hdr_pos % 3 < 2) begin
                    color_hi = {color_hi[7:0], b};
                    hdr_pos = (hdr_pos + 1) & 32'h3FF;
                end else begin
                    idx = hdr_pos / 3;
                    r.ev = (gif_phase == PH_GCT) ? EV_GCT_ENTRY : EV_LCT_ENTRY;
                    r.field_a = idx[15:0];
                    r.rgb_color = {color_hi, b};
                    if (idx + 1 >= table_len) begin
                        gif_phase = (gif_phase == PH_GCT) ? PH_MARK : PH_LZW;
                        hdr_pos = 0;
                    end else begin
                        hdr_pos = (hdr_pos + 1) & 32'h3FF;
                    end
                end
            end
            PH_MARK: begin
                if (b == BLK_EXTENSION) begin
                    gif_phase = PH_EXT_LABEL;
                end else if (b == BLK_IMAGE) begin
                    gif_phase = PH_IMG_DESC;
                    hdr_pos = 0;
                end else if (b == BLK_TRAILER) begin
                    r.ev = EV_TRAILER;
                    gif_phase = PH_DONE;
                end else begin
                    r.ev = EV_BAD_MARKER;
                    r.field_a = {8'h00, b};
                    gif_phase = PH_DONE;
                end
            end
            PH_EXT_LABEL: begin
                r.ev = EV_EXT_START;
                r.field_a = {8'h00, b};
                extensions_done = bump_count(extensions_done);
                gif_phase = PH_EXT_SIZE;
            end
            PH_EXT_SIZE, PH_IMG_SIZE: begin
                if (b == 8'h00) begin
                    if (gif_phase == PH_EXT_SIZE) begin
                        r.ev = EV_EXT_END;
                    end else begin
                        r.ev = EV_IMAGE_END;
                        images_done = bump_count(images_done);
                    end
                    gif_phase = PH_MARK;
                end else begin
                    sub_left = b;
                    gif_phase = (gif_phase == PH_EXT_SIZE) ? PH_EXT_DATA : PH_IMG_DATA;
                end
            end
            PH_EXT_DATA, PH_IMG_DATA: begin
                sub_left = sub_left - 8'd1;
                if (sub_left == 8'h00)
                    gif_phase = (gif_phase == PH_EXT_DATA) ? PH_EXT_SIZE : PH_IMG_SIZE;
            end
            PH_IMG_DESC: begin
                case (hdr_pos)
                    0: acc_x = {8'h00, b};
                    1: acc_x[15:8] = b;
                    2: acc_y = {8'h00, b};
                    3: acc_y[15:8] = b;
                    4: acc_w = {8'h00, b};
                    5: acc_w[15:8] = b;
                    6: acc_h = {8'h00, b};
                    7: acc_h[15:8] = b;
                    default: desc_flags = b;
                endcase
                if (hdr_pos >= 8) begin
                    table_len = color_count(desc_flags);
                    r.ev = EV_IMAGE_DESC;
                    r.field_a = acc_x;
                    r.field_b = acc_y;
                    r.image_width = acc_w;
                    r.image_height = acc_h;
                    r.packed_flags = desc_flags;
                    r.table_entries = table_len;
                    gif_phase = (table_len != 0) ? PH_LCT : PH_LZW;
                    hdr_pos = 0;
                    color_hi = '0;
                end else begin
                    hdr_pos++;
                end
            end
            PH_LZW: begin
                r.ev = EV_LZW_SIZE;
                r.field_a = {8'h00, b};
                gif_phase = PH_IMG_SIZE;
            end
            default: gif_phase = PH_DONE;
        endcase
        r.image_total = images_done[15:0];
        r.extension_count = extensions_done[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    task automatic check_result();
        t_gif_event want;
        if (pending_events.size() == 0) begin
            report_mismatch("event_res of an unexpected transfer", o_m_tuser, 0);
            return;
        end
        want = pending_events.pop_front();
        check_field("event_res", o_m_tuser, want.ev);
        check_field("field_a", o_m_tdata[15:0], want.field_a);
        check_field("field_b", o_m_tdata[31:16], want.field_b);
        check_field("image_width", o_m_tdata[47:32], want.image_width);
        check_field("image_height", o_m_tdata[63:48], want.image_height);
        check_field("packed_flags", o_m_tdata[71:64], want.packed_flags);
        check_field("table_entries", o_m_tdata[80:72], want.table_entries);
        check_field("rgb_color", o_m_tdata[104:81], want.rgb_color);
        check_field("image total", o_m_tdata[120:105], want.image_total);
        check_field("extension_count", o_m_tdata[136:121], want.extension_count);
        check_field("padding", o_m_tdata[143:137], 0);
    endtask

    // Result side: checks each transfer and applies random back-pressure.
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) check_result();
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 16);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Valid is only lowered for a gap, so back-to-back bytes keep it high.
    task automatic send_byte(input logic [7:0] b, input logic restart);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        i_s_tuser <= restart;
        do @(posedge i_clk); while (!o_s_tready);
        pending_events.push_back(parse_byte(b, restart));
        bytes_sent++;
    endtask

    // Sends the n low bytes of seq, the highest of them first.
    task automatic send_bytes(input logic [255:0] seq, input int n, input logic restart_first);
        for (int i = 0; i < n; i++)
            send_byte(seq[8 * (n - 1 - i) +: 8], restart_first && i == 0);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_flags();
        logic [7:0] f;
        f = 8'($urandom);
        // Large tables are kept rare so files stay short.
        if (f[7] && $urandom_range(0, 15) != 0) f[2:0] = 3'($urandom_range(0, 2));
        return f;
    endfunction

    task automatic add_table(input logic [7:0] flags);
        repeat (3 * color_count(flags)) file_bytes.push_back(8'($urandom));
    endtask

    task automatic add_subblocks();
        int unsigned len;
        repeat ($urandom_range(0, 2)) begin
            len = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(1, 8);
            file_bytes.push_back(len[7:0]);
            repeat (len) file_bytes.push_back(8'($urandom));
        end
        file_bytes.push_back(8'h00);
    endtask

    task automatic build_file();
        logic [7:0] flags;
        logic [7:0] marker;
        int unsigned idx;
        file_bytes.push_back("G");
        file_bytes.push_back("I");
        file_bytes.push_back("F");
        file_bytes.push_back("8");
        file_bytes.push_back($urandom_range(0, 1) ? SIG_VER_87 : 8'h39);
        file_bytes.push_back("a");
        if ($urandom_range(0, 9) == 0) file_bytes[$urandom_range(0, 5)] = 8'($urandom);
        flags = pick_flags();
        repeat (4) file_bytes.push_back(8'($urandom));
        file_bytes.push_back(flags);
        repeat (2) file_bytes.push_back(8'($urandom));
        add_table(flags);
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) begin
                file_bytes.push_back(BLK_EXTENSION);
                file_bytes.push_back(8'($urandom));
            end else begin
                file_bytes.push_back(BLK_IMAGE);
                repeat (8) file_bytes.push_back(8'($urandom));
                flags = pick_flags();
                file_bytes.push_back(flags);
                add_table(flags);
                file_bytes.push_back(8'($urandom));
            end
            add_subblocks();
        end
        if ($urandom_range(0, 9) < 8) begin
            file_bytes.push_back(BLK_TRAILER);
        end else begin
            do marker = 8'($urandom);
            while (marker == BLK_EXTENSION || marker == BLK_IMAGE || marker == BLK_TRAILER);
            file_bytes.push_back(marker);
        end
        repeat ($urandom_range(0, 2)) file_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 7) == 0) begin
            idx = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[idx] = 8'($urandom);
        end
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
        file_bytes.delete();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
    endtask

    // A wrong version byte gives a bad signature; later bytes are ignored.
    task automatic test_signature();
        send_bytes({"GIF88a", 8'hFF}, 7, 1'b1);
    endtask

    // 87a file with both color tables, one extension and one image.
    task automatic test_small_file();
        send_bytes({"GIF87a", 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h00, 8'hFF}, 13, 1'b1);
        send_bytes({8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}, 6, 1'b0);
        send_bytes({BLK_EXTENSION, 8'h00, 8'h01, 8'hFF, 8'h00}, 5, 1'b0);
        send_bytes({BLK_IMAGE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF,
                    8'h81}, 10, 1'b0);
        send_bytes({24'h000000, 24'hFFFFFF, 24'h123456, 24'hABCDEF}, 12, 1'b0);
        send_bytes({8'h08, 8'h00, BLK_TRAILER, 8'h2C}, 4, 1'b0);
    endtask

    // Packed byte with every bit but the table flag set gives no table,
    // and an unknown introducer stops the parser.
    task automatic test_bad_marker();
        send_bytes({"GIF89a", 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h00}, 13, 1'b1);
        send_bytes({8'h00, BLK_EXTENSION}, 2, 1'b0);
    endtask

    task automatic test_random_files();
        int unsigned target;
        int unsigned files_done;
        target = bytes_sent + 600;
        files_done = 0;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 5) == 0) begin
                send_noise();
            end else begin
                build_file();
                send_file();
            end
            files_done++;
            if (files_done % 12 == 0) drain_results();
        end
    endtask

    // Extensions and images back to back; no idling from here on.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        send_bytes({"GIF89a", 8'h10, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00}, 13, 1'b1);
        repeat (4) send_bytes({BLK_EXTENSION, 8'hF9, 8'h00}, 3, 1'b0);
        repeat (4)
            send_bytes({BLK_IMAGE, 8'h01, 8'h00, 8'h02, 8'h00, 8'h03, 8'h00, 8'h04, 8'h00,
                        8'h00, 8'h02, 8'h00}, 12, 1'b0);
        send_bytes({BLK_TRAILER}, 1, 1'b0);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= 8'h00;
        i_s_tuser <= 1'b0;
        clear_parser();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_signature();
        test_small_file();
        test_bad_marker();
        test_random_files();
        test_back_to_back();
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
rtl/gbsp_pkg.sv
rtl/gbsp_step.sv
rtl/gif_block_structure_parser_unit.sv
tb/sv/testbench.sv
